[src/lfu_pkg.sv]
// lfu_pkg: shared types and constants for the lfu cache table
// used by lfu_cache_table and lfu_checker; depends on nothing
`default_nettype none
package lfu_pkg;
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CAP_W      = 5;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } out_item_t;

  typedef struct packed {
    logic [31:0]           key;
    logic [31:0]           data;
    logic [COUNT_BITS-1:0] cnt;
    logic [IDX_W-1:0]      rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;
endpackage
`default_nettype wire

[src/lfu_ram.sv]
// lfu_ram: generic one-write one-read synchronous ram, registered read data
// no dependencies
`default_nettype none
module lfu_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

[src/lfu_cache_table.sv]
// lfu_cache_table: top level, sequencer around the entry ram
// depends on lfu_pkg and lfu_ram
//
// One transaction at a time: start is taken while busy is low, and busy stays high
// until the result strobe. Every transaction first sweeps all ENTRIES slots of the
// entry ram (one read a cycle) to find the key, the fill and the eviction victim,
// then takes its decision in S_DEC. A get miss, or a put while capacity is zero,
// then reports at once; any other transaction makes a second read-modify-write
// sweep over the ram to update ranks and counts. The result is on out_item for the
// single cycle in which out_valid is high and cannot be held off. Capacity writes
// are always accepted and must only be made while busy is low.
`default_nettype none
module lfu_cache_table (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire lfu_pkg::in_item_t      in_item,
  output logic                        out_valid,
  output lfu_pkg::out_item_t          out_item,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_data
);
  localparam int IW = lfu_pkg::IDX_W;
  localparam int CB = lfu_pkg::COUNT_BITS;
  localparam int N  = lfu_pkg::ENTRIES;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_DEC  = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [IW:0]   idx_r, idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          kind_r, kind_nxt;
  logic [31:0]   key_r, key_nxt, value_r, value_nxt;
  logic [lfu_pkg::CAP_W-1:0] capacity_r, capacity_nxt;
  logic [N-1:0]  valid_r, valid_nxt;
  logic          present_r, present_nxt;
  logic [IW-1:0] hit_r, hit_nxt, hrank_r, hrank_nxt;
  logic [31:0]   hdata_r, hdata_nxt;
  logic [IW:0]   fill_r, fill_nxt;
  logic          have_r, have_nxt;
  logic [IW-1:0] vic_r, vic_nxt, vrank_r, vrank_nxt;
  logic [CB-1:0] vcnt_r, vcnt_nxt;
  logic [31:0]   vkey_r, vkey_nxt;
  logic          ev_r, ev_nxt, insok_r, insok_nxt;
  logic [IW-1:0] ins_r, ins_nxt;
  lfu_pkg::out_item_t out_r, out_nxt;

  logic          rd_en, wr_en;
  logic [IW-1:0] wr_addr;
  lfu_pkg::entry_t rd_word, wr_word;
  logic [lfu_pkg::ENTRY_W-1:0] rd_raw;

  assign rd_word = lfu_pkg::entry_t'(rd_raw);
  assign rd_en   = (state_r == S_SCAN || state_r == S_UPD) && (idx_r < (IW+1)'(N));

  lfu_ram #(.DEPTH(N), .WIDTH(lfu_pkg::ENTRY_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IW-1:0]),
    .rd_data (rd_raw)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [lfu_pkg::CAP_W-1:0] cap;
    logic                      cap_nz;
    logic [N-1:0]              free;
    logic [IW-1:0]             r;
    lfu_pkg::entry_t           nw;
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rd_vld_nxt   = rd_en;
    rd_idx_nxt   = idx_r[IW-1:0];
    kind_nxt     = kind_r;
    key_nxt      = key_r;
    value_nxt    = value_r;
    capacity_nxt = capacity_r;
    valid_nxt    = valid_r;
    present_nxt  = present_r;
    hit_nxt      = hit_r;
    hrank_nxt    = hrank_r;
    hdata_nxt    = hdata_r;
    fill_nxt     = fill_r;
    have_nxt     = have_r;
    vic_nxt      = vic_r;
    vrank_nxt    = vrank_r;
    vcnt_nxt     = vcnt_r;
    vkey_nxt     = vkey_r;
    ev_nxt       = ev_r;
    ins_nxt      = ins_r;
    insok_nxt    = insok_r;
    out_nxt      = out_r;
    wr_en        = 1'b0;
    wr_addr      = rd_idx_r;
    wr_word      = rd_word;
    nw           = rd_word;
    r            = rd_word.rank;
    free         = '0;
    cap = (capacity_r > lfu_pkg::CAP_W'(N)) ? lfu_pkg::CAP_W'(N) : capacity_r;
    cap_nz = (cap != '0);

    if (cfg_valid) begin
      capacity_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt    = in_item.kind;
          key_nxt     = in_item.key;
          value_nxt   = in_item.value;
          present_nxt = 1'b0;
          have_nxt    = 1'b0;
          fill_nxt    = '0;
          idx_nxt     = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_vld_r && valid_r[rd_idx_r]) begin
          fill_nxt = fill_r + 1'b1;
          if (!present_r && rd_word.key == key_r) begin
            present_nxt = 1'b1;
            hit_nxt     = rd_idx_r;
            hrank_nxt   = rd_word.rank;
            hdata_nxt   = rd_word.data;
          end
          // lowest count, oldest among ties
          if (!have_r || rd_word.cnt < vcnt_r ||
              (rd_word.cnt == vcnt_r && rd_word.rank > vrank_r)) begin
            have_nxt  = 1'b1;
            vic_nxt   = rd_idx_r;
            vcnt_nxt  = rd_word.cnt;
            vrank_nxt = rd_word.rank;
            vkey_nxt  = rd_word.key;
          end
        end
        if (rd_vld_r && rd_idx_r == IW'(N-1)) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ev_nxt = (kind_r == lfu_pkg::KIND_PUT) && !present_r && cap_nz && have_r &&
                 (fill_r >= (IW+1)'(cap));
        free = ~valid_r;
        if (ev_nxt) begin
          free[vic_r] = 1'b1;
        end
        insok_nxt = 1'b0;
        ins_nxt   = '0;
        for (int i = N - 1; i >= 0; i--) begin
          if (free[i]) begin
            insok_nxt = 1'b1;
            ins_nxt   = IW'(i);
          end
        end
        out_nxt.found       = present_r && (kind_r == lfu_pkg::KIND_GET || cap_nz);
        out_nxt.read_value  = (present_r && kind_r == lfu_pkg::KIND_GET) ? hdata_r : '0;
        out_nxt.evicted     = ev_nxt;
        out_nxt.evicted_key = ev_nxt ? vkey_r : '0;
        idx_nxt = '0;
        if (out_nxt.found ||
            (kind_r == lfu_pkg::KIND_PUT && !present_r && cap_nz)) begin
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_UPD: begin
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (present_r) begin
            if (rd_idx_r == hit_r) begin
              nw.rank = '0;
              if (rd_word.cnt != {CB{1'b1}}) begin
                nw.cnt = rd_word.cnt + 1'b1;
              end
              if (kind_r == lfu_pkg::KIND_PUT) begin
                nw.data = value_r;
              end
              wr_en = 1'b1;
            end else if (valid_r[rd_idx_r] && rd_word.rank < hrank_r) begin
              nw.rank = rd_word.rank + 1'b1;
              wr_en   = 1'b1;
            end
          end else begin
            if (insok_r && rd_idx_r == ins_r) begin
              nw.key  = key_r;
              nw.data = value_r;
              nw.cnt  = CB'(1);
              nw.rank = '0;
              wr_en   = 1'b1;
            end else if (valid_r[rd_idx_r] && !(ev_r && rd_idx_r == vic_r)) begin
              if (ev_r && rd_word.rank > vrank_r) begin
                r = r - 1'b1;
              end
              if (insok_r) begin
                r = r + 1'b1;
              end
              nw.rank = r;
              wr_en   = 1'b1;
            end
          end
          wr_word = nw;
          if (rd_idx_r == IW'(N-1)) begin
            if (!present_r) begin
              if (ev_r) begin
                valid_nxt[vic_r] = 1'b0;
              end
              if (insok_r) begin
                valid_nxt[ins_r] = 1'b1;
              end
            end
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      capacity_r <= lfu_pkg::CAP_W'(16);
      rd_vld_r   <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      capacity_r <= capacity_nxt;
      rd_vld_r   <= rd_vld_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    kind_r    <= kind_nxt;
    key_r     <= key_nxt;
    value_r   <= value_nxt;
    present_r <= present_nxt;
    hit_r     <= hit_nxt;
    hrank_r   <= hrank_nxt;
    hdata_r   <= hdata_nxt;
    fill_r    <= fill_nxt;
    have_r    <= have_nxt;
    vic_r     <= vic_nxt;
    vrank_r   <= vrank_nxt;
    vcnt_r    <= vcnt_nxt;
    vkey_r    <= vkey_nxt;
    ev_r      <= ev_nxt;
    ins_r     <= ins_nxt;
    insok_r   <= insok_nxt;
    out_r     <= out_nxt;
  end
endmodule
`default_nettype wire

[src/lfu_checker.sv]
// lfu_checker: port-level assertions for lfu_cache_table, bound to the top level
// depends on lfu_pkg
`default_nettype none
module lfu_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire lfu_pkg::out_item_t out_item
);
  // an accepted transaction holds the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a transaction");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result strobe too long");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.evicted |-> !out_item.found && out_item.read_value == '0)
    else $error("eviction on a hit");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.evicted |-> out_item.evicted_key == '0)
    else $error("stray evicted key");
endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
